[rtl/glyph_atlas_shelf_allocator_core_macros.svh]
// Assertion macros for the shelf allocator. Each expects clk and arst_n in scope.
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_CORE_MACROS_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define GASA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shelf allocator assertion failed");
// Next-cycle implication
`define GASA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shelf allocator assertion failed");
`else
`define GASA_ASSERT_IMP(lbl, ante, cons)
`define GASA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/gasa_pkg.sv]
package gasa_pkg;

	// Row table geometry
	localparam int MAX_ROWS  = 64;
	localparam int ROW_AW    = $clog2(MAX_ROWS);
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

	// Page geometry
	localparam int INITIAL_PAGE_SIZE = 128;
	localparam int MAX_TEX_RESET     = 8192;
	localparam int FIRST_ROW_TOP     = 3;

	// Field widths
	localparam int DIM_W   = 15;
	localparam int POS_W   = 14;
	localparam int H10_W   = 19;
	localparam int ROW_H_W = 16;
	localparam int NRT_W   = 16;

	// h/10 as multiply by reciprocal, exact for h below 81920
	localparam logic [15:0] DIV10_MUL = 16'd52429;
	localparam int DIV10_SHIFT = 19;
	localparam int DIV10_Q_W   = 12;

	// Queue between front and back (power of two)
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [1:0]       status_t;

	localparam status_t STATUS_PLACED     = 2'd0;
	localparam status_t STATUS_SIZE_LIMIT = 2'd1;
	localparam status_t STATUS_ROWS_FULL  = 2'd2;

	// Classified request as it travels through the queue
	typedef struct packed {
		dim_t               w;
		dim_t               h;
		logic [H10_W-1:0]   h_x10;
		logic [ROW_H_W-1:0] row_h;
	} item_t;

	// One row table entry
	typedef struct packed {
		dim_t top;
		dim_t height;
		dim_t used;
	} row_t;

endpackage

[rtl/gasa_intf.sv]
interface gasa_req_if import gasa_pkg::*; ();
	logic valid;
	logic ready;
	dim_t glyph_width;
	dim_t glyph_height;

	modport source (output valid, output glyph_width, output glyph_height, input ready);
	modport sink   (input valid, input glyph_width, input glyph_height, output ready);
endinterface

interface gasa_cfg_if import gasa_pkg::*; ();
	logic valid;
	logic ready;
	dim_t max_texture_size;

	modport source (output valid, output max_texture_size, input ready);
	modport sink   (input valid, input max_texture_size, output ready);
endinterface

interface gasa_rsp_if import gasa_pkg::*; ();
	logic    valid;
	logic    ready;
	pos_t    pos_x;
	pos_t    pos_y;
	dim_t    page_width_out;
	dim_t    page_height_out;
	logic    grew;
	status_t status;

	modport source (output valid, output pos_x, output pos_y, output page_width_out,
		output page_height_out, output grew, output status, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input page_width_out,
		input page_height_out, input grew, input status, output ready);
endinterface

[rtl/gasa_ram.sv]
module gasa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/gasa_front.sv]
module gasa_front import gasa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gasa_req_if.sink req,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	logic [30:0]          div10_prod;
	logic [DIV10_Q_W-1:0] h_div10;
	item_t                cls;
	logic                 push;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// Classify: precompute the height terms the back end compares against
	assign div10_prod = {16'b0, req.glyph_height} * {15'b0, DIV10_MUL};
	assign h_div10    = div10_prod[DIV10_SHIFT +: DIV10_Q_W];

	always_comb begin
		cls.w     = req.glyph_width;
		cls.h     = req.glyph_height;
		cls.h_x10 = {1'b0, req.glyph_height, 3'b000} + {3'b000, req.glyph_height, 1'b0};
		cls.row_h = {1'b0, req.glyph_height} + {{(ROW_H_W-DIV10_Q_W){1'b0}}, h_div10};
	end

	assign req.ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_item    = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/gasa_back.sv]
`include "glyph_atlas_shelf_allocator_core_macros.svh"

module gasa_back import gasa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  dim_t  max_tex,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	gasa_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_GROW = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [ROW_CNT_W-1:0] row_cnt_q;
	logic [NRT_W-1:0]     nrt_q;
	dim_t                 ps_q;
	logic                 grew_q;
	logic                 out_valid_q;
	logic                 pend_we_q;
	logic                 pend_new_q;

	item_t             item_q;
	logic [ROW_AW-1:0] scan_idx_q;
	logic [ROW_AW-1:0] pend_waddr_q;
	row_t              pend_wdata_q;
	pos_t              pend_x_q;
	pos_t              pend_y_q;
	status_t           pend_status_q;
	pos_t              out_x_q;
	pos_t              out_y_q;
	dim_t              out_page_q;
	logic              out_grew_q;
	status_t           out_status_q;

	logic              ram_we;
	logic [ROW_AW-1:0] ram_raddr;
	row_t              rd_row;
	logic [17:0]       ht_x7;
	logic [DIM_W:0]    used_sum;
	logic              fit;
	logic              last_row;
	logic              rows_full;
	logic [NRT_W:0]    row_end;
	logic              need_grow;
	logic [DIM_W:0]    ps_dbl;
	logic              dbl_ok;
	logic              out_free;

	gasa_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (MAX_ROWS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pend_waddr_q),
		.wdata (pend_wdata_q),
		.raddr (ram_raddr),
		.rdata (rd_row)
	);

	// Row fit test on the entry coming out of the table
	assign ht_x7    = {rd_row.height, 3'b000} - {3'b000, rd_row.height};
	assign used_sum = {1'b0, rd_row.used} + {1'b0, item_q.w};
	assign fit      = ({1'b0, ht_x7} <= item_q.h_x10) && (item_q.h <= rd_row.height)
		&& (rd_row.used <= ps_q) && (item_q.w <= (ps_q - rd_row.used));
	assign last_row = (({1'b0, scan_idx_q} + ROW_CNT_W'(1)) == row_cnt_q);

	// New row and page growth tests
	assign rows_full = (row_cnt_q == ROW_CNT_W'(MAX_ROWS));
	assign row_end   = {1'b0, nrt_q} + {1'b0, item_q.row_h};
	assign need_grow = (row_end >= {2'b00, ps_q}) || (item_q.w >= ps_q);
	assign ps_dbl    = {ps_q, 1'b0};
	assign dbl_ok    = (ps_dbl <= {1'b0, max_tex});

	assign out_free  = !out_valid_q || rsp.ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign ram_we    = (state_q == ST_DONE) && out_free && pend_we_q;
	assign ram_raddr = (state_q == ST_SCAN) ? (scan_idx_q + ROW_AW'(1)) : '0;

	// Sequencer and persistent allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_cnt_q   <= '0;
			nrt_q       <= NRT_W'(FIRST_ROW_TOP);
			ps_q        <= DIM_W'(INITIAL_PAGE_SIZE);
			grew_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pend_we_q   <= 1'b0;
			pend_new_q  <= 1'b0;
		end else begin
			// Raise the beat when a result posts, drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						grew_q  <= 1'b0;
						state_q <= (row_cnt_q == '0) ? ST_GROW : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fit) begin
						pend_we_q  <= 1'b1;
						pend_new_q <= 1'b0;
						state_q    <= ST_DONE;
					end else if (last_row) begin
						state_q <= ST_GROW;
					end
				end
				ST_GROW: begin
					if (rows_full) begin
						pend_we_q  <= 1'b0;
						pend_new_q <= 1'b0;
						state_q    <= ST_DONE;
					end else if (need_grow) begin
						if (dbl_ok) begin
							ps_q   <= ps_dbl[DIM_W-1:0];
							grew_q <= 1'b1;
						end else begin
							pend_we_q  <= 1'b0;
							pend_new_q <= 1'b0;
							state_q    <= ST_DONE;
						end
					end else begin
						pend_we_q  <= 1'b1;
						pend_new_q <= 1'b1;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (pend_new_q) begin
							row_cnt_q <= row_cnt_q + ROW_CNT_W'(1);
							nrt_q     <= row_end[NRT_W-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working item, pending result and output register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					item_q     <= q_item;
					scan_idx_q <= '0;
				end
			end
			ST_SCAN: begin
				if (fit) begin
					pend_waddr_q  <= scan_idx_q;
					pend_wdata_q  <= '{top: rd_row.top, height: rd_row.height,
						used: used_sum[DIM_W-1:0]};
					pend_x_q      <= rd_row.used[POS_W-1:0];
					pend_y_q      <= rd_row.top[POS_W-1:0];
					pend_status_q <= STATUS_PLACED;
				end else begin
					scan_idx_q <= scan_idx_q + ROW_AW'(1);
				end
			end
			ST_GROW: begin
				pend_waddr_q  <= row_cnt_q[ROW_AW-1:0];
				pend_wdata_q  <= '{top: nrt_q[DIM_W-1:0],
					height: item_q.row_h[DIM_W-1:0], used: item_q.w};
				if (rows_full) begin
					pend_x_q      <= '0;
					pend_y_q      <= '0;
					pend_status_q <= STATUS_ROWS_FULL;
				end else if (need_grow) begin
					pend_x_q      <= '0;
					pend_y_q      <= '0;
					pend_status_q <= STATUS_SIZE_LIMIT;
				end else begin
					pend_x_q      <= '0;
					pend_y_q      <= nrt_q[POS_W-1:0];
					pend_status_q <= STATUS_PLACED;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_x_q      <= pend_x_q;
					out_y_q      <= pend_y_q;
					out_page_q   <= ps_q;
					out_grew_q   <= grew_q;
					out_status_q <= pend_status_q;
				end
			end
			default: begin
				item_q <= item_q;
			end
		endcase
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.pos_x           = out_x_q;
	assign rsp.pos_y           = out_y_q;
	assign rsp.page_width_out  = out_page_q;
	assign rsp.page_height_out = out_page_q;
	assign rsp.grew            = out_grew_q;
	assign rsp.status          = out_status_q;

	`GASA_ASSERT_IMP(a_rows_bounded, 1'b1, row_cnt_q <= ROW_CNT_W'(MAX_ROWS))
	`GASA_ASSERT_IMP(a_scan_in_table, state_q == ST_SCAN, {1'b0, scan_idx_q} < row_cnt_q)
	`GASA_ASSERT_NXT(a_page_grows_in_grow, state_q != ST_GROW, $stable(ps_q))
	`GASA_ASSERT_NXT(a_row_added, ram_we && pend_new_q, row_cnt_q == $past(row_cnt_q) + ROW_CNT_W'(1))

endmodule

[rtl/glyph_atlas_shelf_allocator_core.sv]
// Shelf allocator for glyph rectangles in a texture atlas page.
// req carries one rectangle (glyph_width, glyph_height) per beat; rsp returns
// exactly one beat per request with pos_x, pos_y, the page size after any
// growth, grew and status (placed, size limit reached, row table full).
// cfg writes max_texture_size; write it only while no request is in flight.
// A two-entry queue sits behind req, so requests keep being taken while the
// back end scans or a result waits on rsp.
// Steps: the back end picks a request from the queue, looks at the rows in
// creation order until one fits (one row table read per cycle), otherwise
// runs the new-row check with one step per page doubling, then posts the
// result; the table holds up to 64 rows. A new request is taken only once
// the previous result has posted, and rows are read through the single
// read port of the row table.
// Reset: row table empty, page 128 x 128, first row top 3, limit 8192.
// A stalled rsp holds its beat; the back end waits with its result pending,
// and req backs up once the queue is full.
module glyph_atlas_shelf_allocator_core import gasa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gasa_req_if.sink   req,
	gasa_cfg_if.sink   cfg,
	gasa_rsp_if.source rsp
);

	dim_t  max_tex_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// Page size limit register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tex_q <= DIM_W'(MAX_TEX_RESET);
		end else if (cfg.valid) begin
			max_tex_q <= cfg.max_texture_size;
		end
	end

	gasa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	gasa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.max_tex (max_tex_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule
